@@ hdl/tcct_pkg.sv @@
`timescale 1ns / 1ps
// Package for the topic channel counter table: sizes, command and status
// codes, item and job structs, hash and counter helpers. No dependencies.
package tcct_pkg;

  localparam int TABLE_ROWS  = 16;
  localparam int KEY_BYTES   = 32;
  localparam int KEY_MAX     = KEY_BYTES - 1;
  localparam int KEY_W       = $clog2(KEY_BYTES);
  localparam int KEY_BITS    = KEY_MAX * 8;
  localparam int OCC_W       = $clog2(TABLE_ROWS + 1);
  localparam int ROW_IW      = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
  localparam int MAX_RESULTS = 32;
  localparam int QDEPTH      = 2;

  localparam logic [31:0] FNV_OFFSET = 32'd2166136261;

  localparam logic [1:0] CMD_TOPIC = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  localparam logic [3:0] ST_HIT      = 4'd0;
  localparam logic [3:0] ST_NEW      = 4'd1;
  localparam logic [3:0] ST_FULL     = 4'd2;
  localparam logic [3:0] ST_EMPTY    = 4'd3;
  localparam logic [3:0] ST_NOKEY    = 4'd4;
  localparam logic [3:0] ST_INACTIVE = 4'd5;
  localparam logic [3:0] ST_ROWDATA  = 4'd6;
  localparam logic [3:0] ST_BADROW   = 4'd7;
  localparam logic [3:0] ST_CTRL     = 4'd8;

  localparam logic [1:0] JOB_TOPIC = 2'd0;
  localparam logic [1:0] JOB_CTRL  = 2'd1;
  localparam logic [1:0] JOB_READ  = 2'd2;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] topic_byte;
    logic       topic_last;
    logic [3:0] row_select;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [3:0]  row_number;
    logic [31:0] row_count;
    logic [7:0]  key_char;
    logic        final_result;
    logic [31:0] total_count;
    logic [31:0] other_count;
    logic [4:0]  rows_used;
    logic [31:0] change_seq;
    logic [31:0] key_hash;
  } out_item_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic                start;
    logic                seen;
    logic [KEY_W-1:0]    len;
    logic [31:0]         hash;
    logic [KEY_BITS-1:0] key;
    logic [3:0]          sel;
  } job_t;

  function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] c);
    logic [31:0] x;
    x = h ^ {24'd0, c};
    return x + (x << 1) + (x << 4) + (x << 7) + (x << 8) + (x << 24);
  endfunction

  function automatic logic [31:0] sat_inc(input logic [31:0] v, input logic [31:0] lim);
    return (v < lim) ? v + 32'd1 : v;
  endfunction

  function automatic logic [KEY_BITS-1:0] key_mask(input logic [KEY_W-1:0] len);
    logic [KEY_BITS-1:0] m;
    for (int i = 0; i < KEY_MAX; i++) begin
      m[i*8 +: 8] = (i < int'(len)) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

@@ hdl/tcct_ram.sv @@
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module tcct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                            wr_data,
  input  logic                                        rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end
endmodule

@@ hdl/tcct_fifo.sv @@
`timescale 1ns / 1ps
// Short job queue between the parser front and the table back.
// Depends on tcct_pkg.
module tcct_fifo import tcct_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t pop_job,
  output logic empty
);
  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  job_t          mem_r [QDEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  assign full    = (cnt_r == CW'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_job = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == PW'(QDEPTH - 1)) ? '0 : wp_r + PW'(1);
      if (pop)  rp_r <= (rp_r == PW'(QDEPTH - 1)) ? '0 : rp_r + PW'(1);
      cnt_r <= cnt_r + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_job;
  end
endmodule

@@ hdl/tcct_front.sv @@
`timescale 1ns / 1ps
// Front part: accepts items, parses topic bytes into keys and hashes,
// and pushes one job per finished topic or command. Depends on tcct_pkg.
module tcct_front import tcct_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_item,
  input  logic     q_full,
  output logic     q_push,
  output job_t     q_job
);
  logic [2:0]          prog_r, prog_nxt;
  logic                found_r, found_nxt, fbd_r, fbd_nxt, mkd_r, mkd_nxt;
  logic                seen_r, seen_nxt;
  logic [KEY_W-1:0]    fb_len_r, fb_len_nxt, mk_len_r, mk_len_nxt;
  logic [31:0]         fb_h_r, fb_h_nxt, mk_h_r, mk_h_nxt;
  logic [KEY_BITS-1:0] fb_key_r, fb_key_nxt, mk_key_r, mk_key_nxt;
  logic [7:0]          c;
  logic                acc;

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;
  assign c        = in_item.topic_byte;

  function automatic logic [2:0] mark_next(input logic [2:0] q, input logic [7:0] b);
    logic [2:0] r;
    r = 3'd0;
    case (q)
      3'd0: r = (b == "/") ? 3'd1 : 3'd0;
      3'd1: r = (b == "2") ? 3'd2 : ((b == "/") ? 3'd1 : 3'd0);
      3'd2: r = (b == "/") ? 3'd3 : 3'd0;
      3'd3: r = (b == "e") ? 3'd4 : ((b == "2") ? 3'd2 : ((b == "/") ? 3'd1 : 3'd0));
      3'd4: r = (b == "/") ? 3'd5 : 3'd0;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  always_comb begin
    prog_nxt   = prog_r;
    found_nxt  = found_r;
    fbd_nxt    = fbd_r;
    mkd_nxt    = mkd_r;
    seen_nxt   = seen_r;
    fb_len_nxt = fb_len_r;
    mk_len_nxt = mk_len_r;
    fb_h_nxt   = fb_h_r;
    mk_h_nxt   = mk_h_r;
    fb_key_nxt = fb_key_r;
    mk_key_nxt = mk_key_r;
    q_push     = 1'b0;
    q_job      = '0;
    if (acc) begin
      unique case (in_item.command)
        CMD_TOPIC: begin
          if (c != 8'd0) begin
            seen_nxt = 1'b1;
            if (!fbd_r) begin
              if (c == "/") begin
                fbd_nxt = 1'b1;
              end else if (fb_len_r < KEY_W'(KEY_MAX)) begin
                fb_key_nxt[fb_len_r*8 +: 8] = c;
                fb_len_nxt = fb_len_r + KEY_W'(1);
                fb_h_nxt   = fnv_step(fb_h_r, c);
              end
            end
            if (found_r) begin
              if (!mkd_r) begin
                if (c == "/") begin
                  mkd_nxt = 1'b1;
                end else if (mk_len_r < KEY_W'(KEY_MAX)) begin
                  mk_key_nxt[mk_len_r*8 +: 8] = c;
                  mk_len_nxt = mk_len_r + KEY_W'(1);
                  mk_h_nxt   = fnv_step(mk_h_r, c);
                end
              end
            end else begin
              prog_nxt = mark_next(prog_r, c);
              if (prog_nxt >= 3'd5) found_nxt = 1'b1;
            end
          end
          if (c == 8'd0 || in_item.topic_last) begin
            q_push     = 1'b1;
            q_job.kind = JOB_TOPIC;
            q_job.seen = seen_nxt;
            q_job.len  = found_nxt ? mk_len_nxt : fb_len_nxt;
            q_job.hash = found_nxt ? mk_h_nxt : fb_h_nxt;
            q_job.key  = found_nxt ? mk_key_nxt : fb_key_nxt;
            prog_nxt   = 3'd0;
            found_nxt  = 1'b0;
            fbd_nxt    = 1'b0;
            mkd_nxt    = 1'b0;
            seen_nxt   = 1'b0;
            fb_len_nxt = '0;
            mk_len_nxt = '0;
            fb_h_nxt   = FNV_OFFSET;
            mk_h_nxt   = FNV_OFFSET;
          end
        end
        CMD_START, CMD_STOP: begin
          q_push      = 1'b1;
          q_job.kind  = JOB_CTRL;
          q_job.start = (in_item.command == CMD_START);
        end
        CMD_READ: begin
          q_push     = 1'b1;
          q_job.kind = JOB_READ;
          q_job.sel  = in_item.row_select;
        end
        default: q_push = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prog_r   <= '0;
      found_r  <= 1'b0;
      fbd_r    <= 1'b0;
      mkd_r    <= 1'b0;
      seen_r   <= 1'b0;
      fb_len_r <= '0;
      mk_len_r <= '0;
      fb_h_r   <= FNV_OFFSET;
      mk_h_r   <= FNV_OFFSET;
    end else begin
      prog_r   <= prog_nxt;
      found_r  <= found_nxt;
      fbd_r    <= fbd_nxt;
      mkd_r    <= mkd_nxt;
      seen_r   <= seen_nxt;
      fb_len_r <= fb_len_nxt;
      mk_len_r <= mk_len_nxt;
      fb_h_r   <= fb_h_nxt;
      mk_h_r   <= mk_h_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fb_key_r <= fb_key_nxt;
    mk_key_r <= mk_key_nxt;
  end
endmodule

@@ hdl/tcct_back.sv @@
`timescale 1ns / 1ps
// Back part: pops jobs, searches and updates the row table, drives the
// result register. Depends on tcct_pkg and tcct_ram.
module tcct_back import tcct_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic [31:0] cfg_data,
  input  logic        q_empty,
  input  job_t        q_job,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_EMIT  = 3'd3;
  localparam logic [2:0] S_RWAIT = 3'd4;
  localparam logic [2:0] S_RCHAR = 3'd5;

  logic [2:0]          state_r, state_nxt;
  job_t                job_r, job_nxt;
  logic [31:0]         limit_r;
  logic                mon_r, mon_nxt;
  logic [OCC_W-1:0]    occ_r, occ_nxt, idx_r, idx_nxt;
  logic [31:0]         total_r, total_nxt, other_r, other_nxt, seq_r, seq_nxt;
  logic [KEY_W-1:0]    j_r, j_nxt;
  logic [3:0]          pst_r, pst_nxt, prow_r, prow_nxt;
  logic [31:0]         pcnt_r, pcnt_nxt, phash_r, phash_nxt;
  logic [31:0]         hash_a [TABLE_ROWS];
  logic [31:0]         cnt_a  [TABLE_ROWS];
  logic [KEY_W-1:0]    len_a  [TABLE_ROWS];
  logic                row_wr, cnt_wr;
  logic [31:0]         cnt_wdata;
  logic                ram_rd;
  logic [ROW_IW-1:0]   ram_raddr, ri;
  logic [KEY_BITS-1:0] ram_rdata;
  logic                out_valid_r, out_free, out_load;
  out_item_t           out_r, out_nxt;
  logic                match, last_char;

  assign ri        = idx_r[ROW_IW-1:0];
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign match     = (hash_a[ri] == job_r.hash) && (len_a[ri] == job_r.len) &&
                     (((ram_rdata ^ job_r.key) & key_mask(job_r.len)) == '0);
  assign last_char = (j_r + KEY_W'(1) == len_a[ri]) || (j_r == KEY_W'(MAX_RESULTS - 1));

  tcct_ram #(.WIDTH(KEY_BITS), .DEPTH(TABLE_ROWS)) u_keys (
    .clk     (clk),
    .wr_en   (row_wr),
    .wr_addr (ri),
    .wr_data (job_r.key),
    .rd_en   (ram_rd),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    mon_nxt   = mon_r;
    occ_nxt   = occ_r;
    idx_nxt   = idx_r;
    total_nxt = total_r;
    other_nxt = other_r;
    seq_nxt   = seq_r;
    j_nxt     = j_r;
    pst_nxt   = pst_r;
    prow_nxt  = prow_r;
    pcnt_nxt  = pcnt_r;
    phash_nxt = phash_r;
    q_pop     = 1'b0;
    row_wr    = 1'b0;
    cnt_wr    = 1'b0;
    cnt_wdata = 32'd1;
    ram_rd    = 1'b0;
    ram_raddr = ri;
    out_load  = 1'b0;
    out_nxt   = '0;
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          job_nxt   = q_job;
          prow_nxt  = '0;
          pcnt_nxt  = '0;
          phash_nxt = '0;
          state_nxt = S_EMIT;
          unique case (q_job.kind)
            JOB_CTRL: begin
              pst_nxt = ST_CTRL;
              if (mon_r != q_job.start) begin
                mon_nxt   = q_job.start;
                occ_nxt   = '0;
                total_nxt = '0;
                other_nxt = '0;
                seq_nxt   = seq_r + 32'd1;
              end
            end
            JOB_READ: begin
              if (!mon_r || OCC_W'(q_job.sel) >= occ_r || int'(q_job.sel) >= TABLE_ROWS) begin
                pst_nxt  = ST_BADROW;
                prow_nxt = q_job.sel;
              end else begin
                idx_nxt   = OCC_W'(q_job.sel);
                ram_rd    = 1'b1;
                ram_raddr = ROW_IW'(q_job.sel);
                state_nxt = S_RWAIT;
              end
            end
            default: begin
              if (!mon_r) begin
                pst_nxt = ST_INACTIVE;
              end else if (!q_job.seen) begin
                pst_nxt = ST_EMPTY;
              end else begin
                total_nxt = sat_inc(total_r, limit_r);
                if (q_job.len == '0) begin
                  pst_nxt   = ST_NOKEY;
                  phash_nxt = FNV_OFFSET;
                end else begin
                  idx_nxt   = '0;
                  state_nxt = S_SCAN;
                end
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        phash_nxt = job_r.hash;
        if (idx_r >= occ_r) begin
          state_nxt = S_EMIT;
          if (int'(occ_r) >= TABLE_ROWS) begin
            other_nxt = sat_inc(other_r, limit_r);
            pst_nxt   = ST_FULL;
          end else begin
            row_wr   = 1'b1;
            cnt_wr   = 1'b1;
            occ_nxt  = occ_r + OCC_W'(1);
            seq_nxt  = seq_r + 32'd1;
            pst_nxt  = ST_NEW;
            prow_nxt = 4'(idx_r);
            pcnt_nxt = 32'd1;
          end
        end else begin
          ram_rd    = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (match) begin
          cnt_wr    = 1'b1;
          cnt_wdata = sat_inc(cnt_a[ri], limit_r);
          pst_nxt   = ST_HIT;
          prow_nxt  = 4'(idx_r);
          pcnt_nxt  = cnt_wdata;
          state_nxt = S_EMIT;
        end else begin
          idx_nxt   = idx_r + OCC_W'(1);
          state_nxt = S_SCAN;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load             = 1'b1;
          out_nxt.status       = pst_r;
          out_nxt.row_number   = prow_r;
          out_nxt.row_count    = pcnt_r;
          out_nxt.final_result = 1'b1;
          out_nxt.total_count  = total_r;
          out_nxt.other_count  = other_r;
          out_nxt.rows_used    = 5'(occ_r);
          out_nxt.change_seq   = seq_r;
          out_nxt.key_hash     = phash_r;
          state_nxt            = S_IDLE;
        end
      end
      S_RWAIT: begin
        j_nxt     = '0;
        state_nxt = S_RCHAR;
      end
      S_RCHAR: begin
        if (out_free) begin
          out_load             = 1'b1;
          out_nxt.status       = ST_ROWDATA;
          out_nxt.row_number   = job_r.sel;
          out_nxt.row_count    = cnt_a[ri];
          out_nxt.key_char     = ram_rdata[j_r*8 +: 8];
          out_nxt.final_result = last_char;
          out_nxt.total_count  = total_r;
          out_nxt.other_count  = other_r;
          out_nxt.rows_used    = 5'(occ_r);
          out_nxt.change_seq   = seq_r;
          out_nxt.key_hash     = hash_a[ri];
          j_nxt                = j_r + KEY_W'(1);
          if (last_char) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      limit_r     <= 32'hFFFF_FFFF;
      mon_r       <= 1'b0;
      occ_r       <= '0;
      total_r     <= '0;
      other_r     <= '0;
      seq_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) limit_r <= cfg_data;
      mon_r   <= mon_nxt;
      occ_r   <= occ_nxt;
      total_r <= total_nxt;
      other_r <= other_nxt;
      seq_r   <= seq_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    job_r   <= job_nxt;
    idx_r   <= idx_nxt;
    j_r     <= j_nxt;
    pst_r   <= pst_nxt;
    prow_r  <= prow_nxt;
    pcnt_r  <= pcnt_nxt;
    phash_r <= phash_nxt;
    if (out_load) out_r <= out_nxt;
    if (cnt_wr) cnt_a[ri] <= cnt_wdata;
    if (row_wr) begin
      hash_a[ri] <= job_r.hash;
      len_a[ri]  <= job_r.len;
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(occ_r) <= TABLE_ROWS) else $error("row occupancy above table size");
  a_off_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !mon_r |-> occ_r == '0) else $error("rows held while monitor off");
  a_cmp_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CMP |-> idx_r < occ_r) else $error("compare beyond used rows");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == S_IDLE) else $error("job popped while busy");
endmodule

@@ hdl/topic_channel_counter_table.sv @@
`timescale 1ns / 1ps
// Topic channel counter table top level: front parser, job queue, back table.
// Depends on tcct_pkg, tcct_front, tcct_fifo, tcct_back.
// Topic bytes are taken one per cycle while the two-entry job queue has room;
// a topic ending costs the back one key RAM read and one compare per used row
// searched, and a row read gives one result per key character. The result
// register lets the back finish one job while its result waits. No clearing
// pass after reset.
module topic_channel_counter_table import tcct_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);
  logic q_push, q_full, q_pop, q_empty;
  job_t q_in, q_out;

  assign cfg_ready = 1'b1;

  tcct_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_item(in_item), .q_full(q_full), .q_push(q_push), .q_job(q_in)
  );

  tcct_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_job(q_in), .full(q_full),
    .pop(q_pop), .pop_job(q_out), .empty(q_empty)
  );

  tcct_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid), .cfg_data(cfg_data),
    .q_empty(q_empty), .q_job(q_out), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );
endmodule
